// ----- src/imu_sma_pkg.sv -----
package imu_sma_pkg;

  // Ring geometry
  localparam int DEPTH   = 5;
  localparam int AXES    = 6;
  localparam int HIST_N  = DEPTH * AXES;
  localparam int ADDR_W  = $clog2(HIST_N);
  localparam int AXIS_W  = 3;

  // Running sums hold DEPTH entries of at most 31-bit magnitude plus sign
  localparam int SUM_W   = 33 + $clog2(DEPTH);

  // Shared divider: 36-bit dividend, two quotient bits per cycle
  localparam int DIV_W     = 36;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int DVS_W     = 16;

  // Gyro deg/s to rad/s, pi/180 in Q0.24
  localparam int PI_W = 19;
  localparam int PROD_W = 31 + PI_W;
  localparam logic [PI_W-1:0] PI_OVER_180_Q24 = 19'd292818;

  localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

  // Axes whose sign is flipped: accel X, accel Z, gyro X, gyro Z
  localparam logic [AXES-1:0] FLIP_MASK = 6'b101101;
  localparam logic [AXIS_W-1:0] FIRST_GYRO = 3'd3;
  localparam logic [AXIS_W-1:0] LAST_AXIS  = 3'd5;

  // Configuration registers
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_CNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_CNT  = 2'd1;
  localparam logic [15:0] ACCEL_CNT_RESET = 16'd16384;
  localparam logic [15:0] GYRO_CNT_RESET  = 16'd1310;

endpackage

// ----- src/imu_six_axis_scale_moving_average.sv -----
// Six-axis IMU scaler with a moving-average filter.
// Input channel (in_valid/in_ready): one beat carries six raw signed 16-bit
// counts, three accelerometer and three gyro axes. Output channel
// (out_valid/out_ready): one beat per input beat, the raw counts echoed plus
// the ring average of each scaled axis in Q15.16 (g for accel, rad/s for gyro).
// Config channel (cfg_valid/cfg_ready, always ready): index 0 sets the accel
// sensitivity, index 1 the gyro sensitivity in tenths; other indexes are
// ignored. Write only while no beat is in flight.
// One beat is worked on at a time: a new beat is accepted only after the
// previous one has been staged. Each axis runs a scaling division, a multiply
// step on gyro axes only, a store, then the averaging division; a final step
// stages the result. The cost is set by a single restoring divider retiring
// two quotient bits per cycle, used twice per axis: once for scaling and once
// for the average.
// in_ready is high only while the block is idle. A finished result sits in an
// output register; if the receiver stalls, the next beat may be accepted and
// computed, and it then waits for the register.
// Reset (rst, synchronous) clears the ring and sums, restores the default
// sensitivities and drops any pending result.
module imu_six_axis_scale_moving_average (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] accel_x_raw,
  input  logic signed [15:0] accel_y_raw,
  input  logic signed [15:0] accel_z_raw,
  input  logic signed [15:0] gyro_x_raw,
  input  logic signed [15:0] gyro_y_raw,
  input  logic signed [15:0] gyro_z_raw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] accel_x_echo,
  output logic signed [15:0] accel_y_echo,
  output logic signed [15:0] accel_z_echo,
  output logic signed [15:0] gyro_x_echo,
  output logic signed [15:0] gyro_y_echo,
  output logic signed [15:0] gyro_z_echo,
  output logic signed [31:0] accel_x_mean,
  output logic signed [31:0] accel_y_mean,
  output logic signed [31:0] accel_z_mean,
  output logic signed [31:0] gyro_x_mean,
  output logic signed [31:0] gyro_y_mean,
  output logic signed [31:0] gyro_z_mean,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [imu_sma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_DIV, S_MUL, S_STORE, S_MLOAD, S_MDIV, S_MSTORE, S_DONE
  } state_t;

  state_t state;
  logic [imu_sma_pkg::AXIS_W-1:0]  axis;
  logic [imu_sma_pkg::ADDR_W-1:0]  addr;
  logic [imu_sma_pkg::CNT_W-1:0]   cnt;
  logic [imu_sma_pkg::DVS_W-1:0]   rem;
  logic [imu_sma_pkg::DVS_W-1:0]   dvs;
  logic [imu_sma_pkg::DIV_W-1:0]   quo;
  logic                            neg;
  logic [imu_sma_pkg::PROD_W-1:0]  prod;
  logic [15:0]                     accel_cnt_per_g;
  logic [15:0]                     gyro_cnt_per_dps;

  // History ring and its valid bits
  logic signed [31:0] hist [imu_sma_pkg::HIST_N];
  logic [imu_sma_pkg::HIST_N-1:0] vld;
  logic signed [31:0] old_data;
  logic               old_vld;

  logic signed [imu_sma_pkg::SUM_W-1:0] sums [imu_sma_pkg::AXES];
  logic signed [15:0] raw_w  [imu_sma_pkg::AXES];
  logic signed [31:0] mean_w [imu_sma_pkg::AXES];
  logic signed [15:0] echo_q [imu_sma_pkg::AXES];
  logic signed [31:0] mean_q [imu_sma_pkg::AXES];

  // Datapath nets
  logic signed [15:0] raw_sel;
  logic [15:0]        raw_mag;
  logic [18:0]        raw_mag10;
  logic               is_gyro;
  logic [15:0]        accel_dvs;
  logic [15:0]        gyro_dvs;
  logic [imu_sma_pkg::DVS_W:0]   r1, r2;
  logic                          ge1, ge2;
  logic [imu_sma_pkg::DVS_W-1:0] r1s, r2s;
  logic [imu_sma_pkg::DIV_W-1:0] q1, q2;
  logic [30:0]        quo_sat;
  logic [30:0]        mag_sel;
  logic signed [31:0] scaled_pos;
  logic signed [31:0] scaled;
  logic signed [31:0] old_val;
  logic signed [imu_sma_pkg::SUM_W-1:0] sum_sel;
  logic signed [imu_sma_pkg::SUM_W-1:0] sum_next;
  logic [imu_sma_pkg::SUM_W-1:0]        sum_mag;
  logic signed [31:0] mean_pos;
  logic signed [31:0] mean_val;
  logic               last_step;
  logic               stage_out;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Operand selection for the current axis
  assign raw_sel   = raw_w[axis];
  assign raw_mag   = raw_sel[15] ? 16'(-raw_sel) : 16'(raw_sel);
  assign raw_mag10 = {raw_mag, 3'b000} + {2'b00, raw_mag, 1'b0};
  assign is_gyro   = (axis >= imu_sma_pkg::FIRST_GYRO);
  assign accel_dvs = (accel_cnt_per_g == 16'd0) ? 16'd1 : accel_cnt_per_g;
  assign gyro_dvs  = (gyro_cnt_per_dps == 16'd0) ? 16'd1 : gyro_cnt_per_dps;

  // Two restoring divide steps per cycle
  always_comb begin
    r1  = {rem, quo[imu_sma_pkg::DIV_W-1]};
    ge1 = (r1 >= {1'b0, dvs});
    r1s = ge1 ? imu_sma_pkg::DVS_W'(r1 - {1'b0, dvs}) : r1[imu_sma_pkg::DVS_W-1:0];
    q1  = {quo[imu_sma_pkg::DIV_W-2:0], ge1};
    r2  = {r1s, q1[imu_sma_pkg::DIV_W-1]};
    ge2 = (r2 >= {1'b0, dvs});
    r2s = ge2 ? imu_sma_pkg::DVS_W'(r2 - {1'b0, dvs}) : r2[imu_sma_pkg::DVS_W-1:0];
    q2  = {q1[imu_sma_pkg::DIV_W-2:0], ge2};
  end

  assign last_step = (cnt == imu_sma_pkg::CNT_W'(imu_sma_pkg::DIV_STEPS - 1));

  // Saturate the quotient magnitude (gyro axes take its product with pi/180) and apply the sign
  assign quo_sat    = (quo[imu_sma_pkg::DIV_W-1:31] != '0) ? imu_sma_pkg::MAG_MAX
                                                           : quo[30:0];
  assign mag_sel    = is_gyro ? 31'(prod[imu_sma_pkg::PROD_W-1:24]) : quo_sat;
  assign scaled_pos = {1'b0, mag_sel};
  assign scaled     = neg ? -scaled_pos : scaled_pos;

  // Running sum update: drop the overwritten entry, add the new one
  assign old_val  = old_vld ? old_data : 32'sd0;
  assign sum_sel  = sums[axis];
  assign sum_next = sum_sel - imu_sma_pkg::SUM_W'(old_val)
                            + imu_sma_pkg::SUM_W'(scaled);
  assign sum_mag  = sum_sel[imu_sma_pkg::SUM_W-1] ? -sum_sel : sum_sel;

  assign mean_pos = {1'b0, quo[30:0]};
  assign mean_val = neg ? -mean_pos : mean_pos;

  // Result moves into the output register once that register is free
  assign stage_out = (state == S_DONE) && (!out_valid || out_ready);

  // History memory
  always_ff @(posedge clk) begin
    if (state == S_STORE) begin
      hist[addr] <= scaled;
    end
    old_data <= hist[addr];
  end

  // Sequencer, divider registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      axis             <= '0;
      addr             <= '0;
      cnt              <= '0;
      vld              <= '0;
      old_vld          <= 1'b0;
      out_valid        <= 1'b0;
      accel_cnt_per_g  <= imu_sma_pkg::ACCEL_CNT_RESET;
      gyro_cnt_per_dps <= imu_sma_pkg::GYRO_CNT_RESET;
      for (int i = 0; i < imu_sma_pkg::AXES; i++) begin
        sums[i] <= '0;
      end
    end else begin
      old_vld <= vld[addr];

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          imu_sma_pkg::CFG_ACCEL_CNT: accel_cnt_per_g  <= cfg_data;
          imu_sma_pkg::CFG_GYRO_CNT:  gyro_cnt_per_dps <= cfg_data;
          default: ;
        endcase
      end

      // Output beat: set when staged, cleared when taken
      if (stage_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            raw_w[0] <= accel_x_raw;
            raw_w[1] <= accel_y_raw;
            raw_w[2] <= accel_z_raw;
            raw_w[3] <= gyro_x_raw;
            raw_w[4] <= gyro_y_raw;
            raw_w[5] <= gyro_z_raw;
            axis     <= '0;
            state    <= S_LOAD;
          end
        end
        S_LOAD: begin
          neg <= raw_sel[15] ^ imu_sma_pkg::FLIP_MASK[axis];
          quo <= is_gyro ? imu_sma_pkg::DIV_W'({raw_mag10, 16'h0000})
                         : imu_sma_pkg::DIV_W'({raw_mag, 16'h0000});
          dvs <= is_gyro ? gyro_dvs : accel_dvs;
          rem <= '0;
          cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= r2s;
          quo <= q2;
          cnt <= cnt + 1'b1;
          if (last_step) begin
            state <= is_gyro ? S_MUL : S_STORE;
          end
        end
        S_MUL: begin
          prod  <= quo_sat * imu_sma_pkg::PI_OVER_180_Q24;
          state <= S_STORE;
        end
        S_STORE: begin
          sums[axis] <= sum_next;
          vld[addr]  <= 1'b1;
          addr <= (addr == imu_sma_pkg::ADDR_W'(imu_sma_pkg::HIST_N - 1)) ? '0
                                                                          : addr + 1'b1;
          state <= S_MLOAD;
        end
        S_MLOAD: begin
          neg <= sum_sel[imu_sma_pkg::SUM_W-1];
          quo <= imu_sma_pkg::DIV_W'(sum_mag[imu_sma_pkg::SUM_W-2:0]);
          dvs <= imu_sma_pkg::DVS_W'(imu_sma_pkg::DEPTH);
          rem <= '0;
          cnt <= '0;
          state <= S_MDIV;
        end
        S_MDIV: begin
          rem <= r2s;
          quo <= q2;
          cnt <= cnt + 1'b1;
          if (last_step) begin
            state <= S_MSTORE;
          end
        end
        S_MSTORE: begin
          mean_w[axis] <= mean_val;
          if (axis == imu_sma_pkg::LAST_AXIS) begin
            state <= S_DONE;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_LOAD;
          end
        end
        S_DONE: begin
          if (stage_out) begin
            for (int i = 0; i < imu_sma_pkg::AXES; i++) begin
              echo_q[i] <= raw_w[i];
              mean_q[i] <= mean_w[i];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign accel_x_echo = echo_q[0];
  assign accel_y_echo = echo_q[1];
  assign accel_z_echo = echo_q[2];
  assign gyro_x_echo  = echo_q[3];
  assign gyro_y_echo  = echo_q[4];
  assign gyro_z_echo  = echo_q[5];
  assign accel_x_mean = mean_q[0];
  assign accel_y_mean = mean_q[1];
  assign accel_z_mean = mean_q[2];
  assign gyro_x_mean  = mean_q[3];
  assign gyro_y_mean  = mean_q[4];
  assign gyro_z_mean  = mean_q[5];

`ifndef SYNTHESIS
  // An accepted beat blocks the input until its result is staged
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a beat was in flight");

  // The ring write pointer stays inside the memory
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    addr <= imu_sma_pkg::ADDR_W'(imu_sma_pkg::HIST_N - 1))
    else $error("history address out of range");

  // A scaling division ends in the multiply or the store step
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && last_step |=> state == S_MUL || state == S_STORE)
    else $error("scaling division did not retire");

  // A new result appears only from the done step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the done step");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  // Beat limits and pacing
  localparam int unsigned RUN_LIMIT      = 6_000_000;
  localparam int unsigned SETTLE_CYCLES  = 300;
  localparam int unsigned ITEMS_PER_PASS = 250;
  localparam int unsigned PASS_COUNT     = 7;

  // Scaling constants: pi/180 in Q0.24, magnitude ceiling of Q15.16
  localparam longint unsigned DEG_TO_RAD_Q24 = 64'd292818;
  localparam longint unsigned SAT_MAG        = 64'h7FFF_FFFF;
  // accel X, accel Z, gyro X, gyro Z come out negated
  localparam bit [0:5] NEGATED_AXES = 6'b101101;

  typedef logic [0:5][15:0] imu_raw_t;

  typedef struct packed {
    logic [0:5][15:0] echo;
    logic [0:5][31:0] mean;
  } filter_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic signed [15:0] accel_x_raw = '0;
  logic signed [15:0] accel_y_raw = '0;
  logic signed [15:0] accel_z_raw = '0;
  logic signed [15:0] gyro_x_raw = '0;
  logic signed [15:0] gyro_y_raw = '0;
  logic signed [15:0] gyro_z_raw = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [15:0] accel_x_echo, accel_y_echo, accel_z_echo;
  logic signed [15:0] gyro_x_echo, gyro_y_echo, gyro_z_echo;
  logic signed [31:0] accel_x_mean, accel_y_mean, accel_z_mean;
  logic signed [31:0] gyro_x_mean, gyro_y_mean, gyro_z_mean;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [imu_sma_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Predictor state: sensitivities and the ring of scaled samples
  logic [15:0] accel_div = imu_sma_pkg::ACCEL_CNT_RESET;
  logic [15:0] gyro_div  = imu_sma_pkg::GYRO_CNT_RESET;
  int          ring_hist [imu_sma_pkg::DEPTH][6];
  int unsigned ring_slot = 0;

  filter_out_t pending_means[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          tx_gaps = 1'b0;
  bit          rx_stalls = 1'b0;
  int unsigned rx_hold = 0;

  string axis_names [6] = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y", "gyro_z"};

  imu_six_axis_scale_moving_average dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .accel_x_raw  (accel_x_raw),
    .accel_y_raw  (accel_y_raw),
    .accel_z_raw  (accel_z_raw),
    .gyro_x_raw   (gyro_x_raw),
    .gyro_y_raw   (gyro_y_raw),
    .gyro_z_raw   (gyro_z_raw),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accel_x_echo (accel_x_echo),
    .accel_y_echo (accel_y_echo),
    .accel_z_echo (accel_z_echo),
    .gyro_x_echo  (gyro_x_echo),
    .gyro_y_echo  (gyro_y_echo),
    .gyro_z_echo  (gyro_z_echo),
    .accel_x_mean (accel_x_mean),
    .accel_y_mean (accel_y_mean),
    .accel_z_mean (accel_z_mean),
    .gyro_x_mean  (gyro_x_mean),
    .gyro_y_mean  (gyro_y_mean),
    .gyro_z_mean  (gyro_z_mean),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 24);
    else return $urandom_range(25, 300);
  endfunction

  // Sign applied after saturating the magnitude
  function automatic int signed_sat(bit neg, longint unsigned mag);
    int v;
    v = int'((mag > SAT_MAG) ? SAT_MAG : mag);
    return neg ? -v : v;
  endfunction

  function automatic longint unsigned raw_mag(logic [15:0] raw);
    int r;
    r = $signed(raw);
    return (r < 0) ? longint'(-r) : longint'(r);
  endfunction

  // Accel counts to g, Q15.16
  function automatic int accel_to_g(logic [15:0] raw, bit flip);
    longint unsigned d;
    d = (accel_div == 0) ? 64'd1 : longint'(accel_div);
    return signed_sat(raw[15] != flip, (raw_mag(raw) << 16) / d);
  endfunction

  // Gyro counts to deg/s, saturated, then to rad/s, Q15.16
  function automatic int gyro_to_rad(logic [15:0] raw, bit flip);
    longint unsigned d, deg;
    d = (gyro_div == 0) ? 64'd1 : longint'(gyro_div);
    deg = ((raw_mag(raw) * 10) << 16) / d;
    if (deg > SAT_MAG) deg = SAT_MAG;
    return signed_sat(raw[15] != flip, (deg * DEG_TO_RAD_Q24) >> 24);
  endfunction

  // Push one sample into the ring and return the echo plus the ring means
  function automatic filter_out_t advance_filter(imu_raw_t raw);
    filter_out_t res;
    longint total;
    for (int a = 0; a < 6; a++) begin
      ring_hist[ring_slot][a] = (a < 3) ? accel_to_g(raw[a], NEGATED_AXES[a])
                                        : gyro_to_rad(raw[a], NEGATED_AXES[a]);
    end
    ring_slot = (ring_slot + 1 == imu_sma_pkg::DEPTH) ? 0 : ring_slot + 1;
    for (int a = 0; a < 6; a++) begin
      total = 0;
      for (int k = 0; k < imu_sma_pkg::DEPTH; k++) total += ring_hist[k][a];
      res.echo[a] = raw[a];
      res.mean[a] = 32'(total / imu_sma_pkg::DEPTH);
    end
    return res;
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 15))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      4: return 16'sh0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // One sample beat; prediction taken at the accepting edge
  task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
    imu_raw_t raw;
    int unsigned gap;
    raw = {ax, ay, az, gx, gy, gz};
    in_valid    <= 1'b1;
    accel_x_raw <= ax;
    accel_y_raw <= ay;
    accel_z_raw <= az;
    gyro_x_raw  <= gx;
    gyro_y_raw  <= gy;
    gyro_z_raw  <= gz;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_means.push_back(advance_filter(raw));
    gap = tx_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    send_sample(rand_axis(), rand_axis(), rand_axis(),
                rand_axis(), rand_axis(), rand_axis());
  endtask

  task automatic write_register(logic [imu_sma_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      imu_sma_pkg::CFG_ACCEL_CNT: accel_div = val;
      imu_sma_pkg::CFG_GYRO_CNT:  gyro_div = val;
      default: ;
    endcase
  endtask

  // Both sensitivities, then a write to an unused index that must be ignored
  task automatic configure(logic [15:0] accel_val, logic [15:0] gyro_val);
    logic [imu_sma_pkg::CFG_IDX_W-1:0] spare;
    write_register(imu_sma_pkg::CFG_ACCEL_CNT, accel_val);
    write_register(imu_sma_pkg::CFG_GYRO_CNT, gyro_val);
    do spare = imu_sma_pkg::CFG_IDX_W'($urandom);
    while (spare == imu_sma_pkg::CFG_ACCEL_CNT || spare == imu_sma_pkg::CFG_GYRO_CNT);
    write_register(spare, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Block idle once every predicted beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
  endtask

  // Ring starts cleared: the first DEPTH-1 means average in zeros
  task automatic test_ring_start();
    send_sample(16'sh4000, 16'sh4000, 16'sh4000, 16'sh0083, 16'sh0083, 16'sh0083);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(16'shFFFF, 16'sh0001, 16'shFFFF, 16'sh0001, 16'shFFFF, 16'sh0001);
    send_sample(16'sh1234, 16'shEDCC, 16'sh5555, 16'shAAAA, 16'sh0F0F, 16'shF0F0);
    drain_results();
  endtask

  // Divisor of one drives full-scale gyro counts and accel 0x8000 into the magnitude ceiling
  task automatic test_saturation();
    configure(16'd1, 16'd1);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_sample(16'shFFFF, 16'sh0001, 16'shFFFF, 16'sh0001, 16'shFFFF, 16'sh0001);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF, 16'sh7FFF, 16'sh8000);
    drain_results();
  endtask

  // Zero sensitivity behaves as one
  task automatic test_zero_sensitivity();
    configure(16'd0, 16'd0);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh0001, 16'sh7FFF, 16'sh8000, 16'sh0001);
    send_sample(16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh8000, 16'sh7FFF, 16'shFFFF);
    send_sample(16'sh0064, 16'shFF9C, 16'sh0000, 16'sh0064, 16'shFF9C, 16'sh0000);
    drain_results();
  endtask

  // Largest divisor: small gyro counts truncate to zero, small accel counts to one LSB
  task automatic test_widest_sensitivity();
    configure(16'hFFFF, 16'hFFFF);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh0001, 16'shFFFF, 16'sh0001, 16'shFFFF, 16'sh0001, 16'shFFFF);
    send_sample(16'shFFFF, 16'sh0001, 16'shFFFF, 16'sh0001, 16'shFFFF, 16'sh0001);
    drain_results();
  endtask

  // Random samples under several sensitivity settings and pacing mixes
  task automatic test_random_passes();
    logic [15:0] a_sens, g_sens;
    for (int p = 0; p < PASS_COUNT; p++) begin
      case (p)
        0: begin
          a_sens = imu_sma_pkg::ACCEL_CNT_RESET;
          g_sens = imu_sma_pkg::GYRO_CNT_RESET;
        end
        1: begin a_sens = 16'hFFFF; g_sens = 16'hFFFF; end
        2: begin a_sens = 16'd1; g_sens = 16'd1; end
        4: begin a_sens = 16'($urandom_range(0, 64)); g_sens = 16'($urandom_range(0, 64)); end
        default: begin a_sens = 16'($urandom); g_sens = 16'($urandom); end
      endcase
      tx_gaps   = (p != 1) && (p != 5);
      rx_stalls = (p != 1) && (p != 6);
      configure(a_sens, g_sens);
      repeat (ITEMS_PER_PASS) send_random();
      drain_results();
    end
  endtask

  // Receiver: random stalls, or always ready
  always @(posedge clk) begin
    if (rst || !rx_stalls) begin
      out_ready <= !rst;
      rx_hold   <= 0;
    end else if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold   <= rx_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) rx_hold <= pick_gap();
    end
  end

  // Compare each result beat against the oldest prediction
  always @(posedge clk) begin : check_beat
    filter_out_t seen, want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      seen.echo = {accel_x_echo, accel_y_echo, accel_z_echo,
                   gyro_x_echo, gyro_y_echo, gyro_z_echo};
      seen.mean = {accel_x_mean, accel_y_mean, accel_z_mean,
                   gyro_x_mean, gyro_y_mean, gyro_z_mean};
      if (pending_means.size() == 0) begin
        $error("result beat with no sample outstanding");
        mismatches++;
      end else begin
        want = pending_means.pop_front();
        for (int a = 0; a < 6; a++) begin
          if (seen.echo[a] !== want.echo[a]) begin
            $error("%s_echo expected %0d got %0d", axis_names[a],
                   $signed(want.echo[a]), $signed(seen.echo[a]));
            mismatches++;
          end
          if (seen.mean[a] !== want.mean[a]) begin
            $error("%s_mean expected %0d got %0d", axis_names[a],
                   $signed(want.mean[a]), $signed(seen.mean[a]));
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < imu_sma_pkg::DEPTH; k++)
      for (int a = 0; a < 6; a++) ring_hist[k][a] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_ring_start();
    test_saturation();
    test_zero_sensitivity();
    test_widest_sensitivity();
    test_random_passes();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_means.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
